// ===== hw/rtl/okvt_pkg.sv =====
// Shared types and codes for the ordered key/value table.
package okvt_pkg;

   // Field widths of the request and response beats
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 8;
   localparam int OP_BITS    = 3;
   localparam int ST_BITS    = 3;

   // Opcodes
   localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_UPDATE = 3'd2;
   localparam logic [OP_BITS-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_BITS-1:0] OP_LIST   = 3'd4;

   // Response status codes
   localparam logic [ST_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [ST_BITS-1:0] ST_DUP     = 3'd1;
   localparam logic [ST_BITS-1:0] ST_MISSING = 3'd2;
   localparam logic [ST_BITS-1:0] ST_FULL    = 3'd3;
   localparam logic [ST_BITS-1:0] ST_EMPTY   = 3'd4;

   typedef struct packed {
      logic [OP_BITS-1:0]    opcode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ST_BITS-1:0]    status;
      logic [KEY_BITS-1:0]   key_out;
      logic [VALUE_BITS-1:0] value_out;
      logic                  last;
   } rsp_type;

   // Contents of one table cell
   typedef struct packed {
      logic                  used;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // Per-cycle commands broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
      logic update;
      logic rotate;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/okvt_cell.sv =====
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module okvt_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  okvt_pkg::cell_ctrl_type              ctrl,
   input  logic [okvt_pkg::KEY_BITS-1:0]        cmd_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0]      cmd_value,
   input  okvt_pkg::entry_type                  left_entry,
   input  logic                                 left_gt,
   input  okvt_pkg::entry_type                  right_entry,
   input  okvt_pkg::entry_type                  first_entry,
   output okvt_pkg::entry_type                  entry,
   output logic                                 gt,
   output logic                                 match
);

   logic                              used_ff, used_in;
   logic [okvt_pkg::KEY_BITS-1:0]     key_ff, key_in;
   logic [okvt_pkg::VALUE_BITS-1:0]   value_ff, value_in;

   // Compare against the command key
   assign match = used_ff && (key_ff == cmd_key);
   assign gt    = used_ff && (key_ff > cmd_key);

   assign entry = '{used: used_ff, key: key_ff, value: value_ff};

   // Next contents of the cell
   always_comb begin
      used_in  = used_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.insert) begin
         if (left_gt) begin
            // make room: take the left neighbor
            used_in  = left_entry.used;
            key_in   = left_entry.key;
            value_in = left_entry.value;
         end else if (gt || (!used_ff && left_entry.used)) begin
            // insertion point
            used_in  = 1'b1;
            key_in   = cmd_key;
            value_in = cmd_value;
         end
      end else if (ctrl.remove) begin
         // cells at and above the deleted key close the gap
         if (gt || match) begin
            used_in  = right_entry.used;
            key_in   = right_entry.key;
            value_in = right_entry.value;
         end
      end else if (ctrl.update) begin
         if (match) begin
            value_in = cmd_value;
         end
      end else if (ctrl.rotate) begin
         // rotate the used cells left by one, head wraps to the tail
         if (right_entry.used) begin
            key_in   = right_entry.key;
            value_in = right_entry.value;
         end else if (used_ff) begin
            key_in   = first_entry.key;
            value_in = first_entry.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

// ===== hw/rtl/ordered_key_value_table.sv =====
// A request beat is captured in the request register; the execute state then loads
// its response beat into the response register once the response side is free. No
// new request is taken until the sequencer is back in idle. A list walk gives one
// beat per cycle unless the response side stalls, as the chain rotates past cell 0.
// Reset empties the table by clearing the used bit in every cell; keys are not cleared.
module ordered_key_value_table #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  okvt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output okvt_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LIST = 2'd2;

   logic [1:0]                         state_ff, state_in;
   okvt_pkg::req_type                  cmd_ff, cmd_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   list_cnt_ff, list_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   okvt_pkg::rsp_type                  rsp_ff, rsp_in;

   okvt_pkg::cell_ctrl_type            ctrl;
   okvt_pkg::entry_type                cell_entry [CAPACITY];
   logic [CAPACITY-1:0]                cell_gt;
   logic [CAPACITY-1:0]                cell_match;
   logic [CAPACITY-1:0]                cell_used;

   logic                               rsp_free;
   logic                               found;
   logic                               full;
   logic                               list_last;
   logic [okvt_pkg::VALUE_BITS-1:0]    found_value;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      okvt_pkg::entry_type left_e;
      okvt_pkg::entry_type right_e;
      logic                left_g;

      if (i == 0) begin : g_head
         assign left_e = '{used: 1'b1, key: '0, value: '0};
         assign left_g = 1'b0;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_g = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_mid
         assign right_e = cell_entry[i+1];
      end

      okvt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cmd_key     (cmd_ff.key),
         .cmd_value   (cmd_ff.value),
         .left_entry  (left_e),
         .left_gt     (left_g),
         .right_entry (right_e),
         .first_entry (cell_entry[0]),
         .entry       (cell_entry[i]),
         .gt          (cell_gt[i]),
         .match       (cell_match[i])
      );

      assign cell_used[i] = cell_entry[i].used;
   end

   // Lookup result: keys are unique, so at most one cell matches
   always_comb begin
      found_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_match[i]) begin
            found_value = found_value | cell_entry[i].value;
         end
      end
   end

   assign found     = |cell_match;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign list_last = ((list_cnt_ff + CNT_W'(1)) == count_ff);

   // Cell commands
   always_comb begin
      ctrl = '0;
      if (state_ff == S_EXEC && rsp_free) begin
         ctrl.insert = (cmd_ff.opcode == okvt_pkg::OP_INSERT) && !found && !full;
         ctrl.remove = (cmd_ff.opcode == okvt_pkg::OP_DELETE) && found;
         ctrl.update = (cmd_ff.opcode == okvt_pkg::OP_UPDATE) && found;
      end
      ctrl.rotate = (state_ff == S_LIST) && rsp_free;
   end

   // Sequencer and response register
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      list_cnt_in  = list_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               state_in       = S_IDLE;
               rsp_in.key_out = cmd_ff.key;
               rsp_in.value_out = '0;
               rsp_in.last    = 1'b1;
               rsp_in.status  = okvt_pkg::ST_OK;
               rsp_valid_in   = 1'b1;
               case (cmd_ff.opcode)
                  okvt_pkg::OP_INSERT: begin
                     if (found) begin
                        rsp_in.status = okvt_pkg::ST_DUP;
                     end else if (full) begin
                        rsp_in.status = okvt_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  okvt_pkg::OP_DELETE: begin
                     if (found) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        rsp_in.status = okvt_pkg::ST_MISSING;
                     end
                  end
                  okvt_pkg::OP_UPDATE: begin
                     if (!found) begin
                        rsp_in.status = okvt_pkg::ST_MISSING;
                     end
                  end
                  okvt_pkg::OP_SEARCH: begin
                     if (found) begin
                        rsp_in.value_out = found_value;
                     end else begin
                        rsp_in.status = okvt_pkg::ST_MISSING;
                     end
                  end
                  okvt_pkg::OP_LIST: begin
                     if (count_ff == '0) begin
                        rsp_in.status  = okvt_pkg::ST_EMPTY;
                        rsp_in.key_out = '0;
                     end else begin
                        // beats come from the list walk
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        rsp_in       = rsp_ff;
                        list_cnt_in  = '0;
                        state_in     = S_LIST;
                     end
                  end
                  default: begin
                     // undefined opcode: no response
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                     rsp_in       = rsp_ff;
                  end
               endcase
            end
         end
         S_LIST: begin
            if (rsp_free) begin
               rsp_in.status    = okvt_pkg::ST_OK;
               rsp_in.key_out   = cell_entry[0].key;
               rsp_in.value_out = cell_entry[0].value;
               rsp_in.last      = list_last;
               rsp_valid_in     = 1'b1;
               list_cnt_in      = list_cnt_ff + CNT_W'(1);
               if (list_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         list_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         list_cnt_ff  <= list_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // Entry count never passes the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // Used cells agree with the entry count outside the list walk
   a_used_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LIST) |-> ($countones(cell_used) == int'(count_ff)))
      else $error("used cells disagree with entry count");

   // Keys stay unique across the chain
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_match))
      else $error("more than one cell matches the key");

   // A list walk always ends on a last beat before going idle
   a_list_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST && state_in == S_IDLE) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("list walk ended without a last beat");
`endif

endmodule

// ===== dv/tb_ordered_key_value_table.sv =====
// Self-checking testbench for the ordered key/value table: directed and random traffic, scoreboard check.
module tb_ordered_key_value_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = 16;
   localparam int KEY_POOL    = 24;
   localparam int RANDOM_OPS  = 358;
   localparam int ROUND_LEN   = 40;
   localparam int DRAIN_WAIT  = 40;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      okvt_pkg::req_type beat;
      bit                hold;   // wait for every outstanding response before sending
   } stim_item_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   okvt_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   okvt_pkg::rsp_type rsp_data;

   // Shadow copy of the table contents
   logic [okvt_pkg::KEY_BITS-1:0]   tbl_keys [CAPACITY];
   logic [okvt_pkg::VALUE_BITS-1:0] tbl_vals [CAPACITY];
   int                              tbl_count = 0;

   stim_item_type     stim_q[$];
   okvt_pkg::rsp_type awaited_beats[$];
   int                beats_due   = 0;
   int                beats_done  = 0;
   int                error_count = 0;
   int                cycle_count = 0;
   int                gap_left    = 0;
   int                burst_left  = 0;
   int                stall_mode  = 0;
   int                stall_left  = 0;

   ordered_key_value_table #(.CAPACITY(CAPACITY)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic push_beat(input okvt_pkg::rsp_type b);
      awaited_beats.push_back(b);
      beats_due++;
   endtask

   // Apply one accepted request to the shadow table and queue its response beats
   task automatic apply_table_op(input okvt_pkg::req_type r);
      int                hit;
      int                pos;
      okvt_pkg::rsp_type b;
      b         = '0;
      b.key_out = r.key;
      b.last    = 1'b1;
      b.status  = okvt_pkg::ST_OK;
      hit       = -1;
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_keys[i] == r.key) hit = i;
      end
      case (r.opcode)
         okvt_pkg::OP_INSERT: begin
            if (hit >= 0) begin
               b.status = okvt_pkg::ST_DUP;
            end else if (tbl_count >= CAPACITY) begin
               b.status = okvt_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < tbl_count && tbl_keys[pos] < r.key) pos++;
               for (int i = tbl_count; i > pos; i--) begin
                  tbl_keys[i] = tbl_keys[i-1];
                  tbl_vals[i] = tbl_vals[i-1];
               end
               tbl_keys[pos] = r.key;
               tbl_vals[pos] = r.value;
               tbl_count++;
            end
            push_beat(b);
         end
         okvt_pkg::OP_DELETE: begin
            if (hit < 0) begin
               b.status = okvt_pkg::ST_MISSING;
            end else begin
               for (int i = hit; i + 1 < tbl_count; i++) begin
                  tbl_keys[i] = tbl_keys[i+1];
                  tbl_vals[i] = tbl_vals[i+1];
               end
               tbl_count--;
            end
            push_beat(b);
         end
         okvt_pkg::OP_UPDATE: begin
            if (hit < 0) b.status = okvt_pkg::ST_MISSING;
            else tbl_vals[hit] = r.value;
            push_beat(b);
         end
         okvt_pkg::OP_SEARCH: begin
            if (hit < 0) b.status = okvt_pkg::ST_MISSING;
            else b.value_out = tbl_vals[hit];
            push_beat(b);
         end
         okvt_pkg::OP_LIST: begin
            if (tbl_count == 0) begin
               b.status  = okvt_pkg::ST_EMPTY;
               b.key_out = '0;
               push_beat(b);
            end else begin
               for (int i = 0; i < tbl_count; i++) begin
                  b.key_out   = tbl_keys[i];
                  b.value_out = tbl_vals[i];
                  b.last      = (i == tbl_count - 1);
                  push_beat(b);
               end
            end
         end
         default: ;  // undefined opcodes produce nothing
      endcase
   endtask

   task automatic queue_req(input logic [okvt_pkg::OP_BITS-1:0] op,
                            input logic [okvt_pkg::KEY_BITS-1:0] k,
                            input logic [okvt_pkg::VALUE_BITS-1:0] v, input bit hold);
      stim_item_type it;
      it.beat.opcode = op;
      it.beat.key    = k;
      it.beat.value  = v;
      it.hold        = hold;
      stim_q.push_back(it);
   endtask

   // Request driver: bursts with random gaps, payload held while stalled
   always @(posedge clock) begin
      stim_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_table_op(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (stim_q.size() == 0 ||
                         (stim_q[0].hold && (beats_due != beats_done || req_valid))) begin
               req_valid <= 1'b0;
            end else begin
               nxt = stim_q.pop_front();
               req_data  <= nxt.beat;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Response stall pattern: free-running, random, heavy, and long runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 30);
            2:       rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= ($urandom_range(0, 7) == 0) ? ~rsp_stall : rsp_stall;
         endcase
      end
   end

   // Response monitor: compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      okvt_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_done <= beats_done + 1;
         if (awaited_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected response beat %p", rsp_data));
         end else begin
            want = awaited_beats.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.key_out !== want.key_out)
               report_mismatch($sformatf("key_out %h, expected %h",
                                         rsp_data.key_out, want.key_out));
            if (rsp_data.value_out !== want.value_out)
               report_mismatch($sformatf("value_out %h, expected %h",
                                         rsp_data.value_out, want.value_out));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_data.last, want.last));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [okvt_pkg::KEY_BITS-1:0] key_pool [KEY_POOL];
      logic [okvt_pkg::OP_BITS-1:0]  op_order [5];
      int                            cut [3][5];
      int                            counted;
      int                            round_no;
      int                            phase;
      int                            roll;
      logic [okvt_pkg::OP_BITS-1:0]  op;
      logic [okvt_pkg::KEY_BITS-1:0] k;

      op_order = '{okvt_pkg::OP_INSERT, okvt_pkg::OP_DELETE, okvt_pkg::OP_UPDATE,
                   okvt_pkg::OP_SEARCH, okvt_pkg::OP_LIST};
      // cumulative op weights per phase: fill, mixed, drain
      cut = '{'{60, 65, 75, 87, 93}, '{30, 50, 65, 82, 92}, '{10, 60, 70, 82, 92}};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = okvt_pkg::KEY_BITS'($urandom());

      // Directed: empty table, misses, extreme keys and values, duplicate, order
      queue_req(okvt_pkg::OP_LIST,   16'h1234, 8'h56, 0);
      queue_req(okvt_pkg::OP_SEARCH, 16'h0000, 8'h00, 0);
      queue_req(okvt_pkg::OP_DELETE, 16'hFFFF, 8'hFF, 0);
      queue_req(okvt_pkg::OP_UPDATE, 16'h00FF, 8'h3C, 0);
      queue_req(okvt_pkg::OP_INSERT, 16'h8000, 8'h11, 0);
      queue_req(okvt_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 0);
      queue_req(okvt_pkg::OP_INSERT, 16'h0000, 8'h00, 0);
      queue_req(okvt_pkg::OP_INSERT, 16'h00FF, 8'h80, 0);
      queue_req(okvt_pkg::OP_INSERT, 16'hFFFF, 8'h01, 0);
      queue_req(okvt_pkg::OP_SEARCH, 16'hFFFF, 8'h00, 0);
      queue_req(okvt_pkg::OP_UPDATE, 16'h0000, 8'hAA, 0);
      queue_req(okvt_pkg::OP_SEARCH, 16'h0000, 8'h00, 0);
      queue_req(okvt_pkg::OP_LIST,   16'h0000, 8'h00, 0);
      // undefined opcodes must leave the table alone
      queue_req(3'd5, 16'hFFFF, 8'hFF, 0);
      queue_req(3'd6, 16'h0000, 8'h00, 0);
      queue_req(3'd7, 16'h8000, 8'h55, 0);
      queue_req(okvt_pkg::OP_DELETE, 16'h8000, 8'h00, 0);
      queue_req(okvt_pkg::OP_DELETE, 16'h0000, 8'h00, 0);
      queue_req(okvt_pkg::OP_DELETE, 16'hFFFF, 8'h00, 0);
      queue_req(okvt_pkg::OP_LIST,   16'hFFFF, 8'hFF, 0);
      queue_req(okvt_pkg::OP_DELETE, 16'h00FF, 8'h00, 0);
      queue_req(okvt_pkg::OP_LIST,   16'h0000, 8'h00, 1);

      // Random rounds cycling through fill, mixed and drain biases
      counted  = 0;
      round_no = 0;
      while (counted < RANDOM_OPS) begin
         phase = round_no % 3;
         for (int n = 0; n < ROUND_LEN && counted < RANDOM_OPS; n++) begin
            roll = $urandom_range(0, 99);
            op   = okvt_pkg::OP_BITS'($urandom_range(5, 7));
            for (int j = 4; j >= 0; j--) begin
               if (roll < cut[phase][j]) op = op_order[j];
            end
            k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL-1)]
                                             : okvt_pkg::KEY_BITS'($urandom());
            queue_req(op, k, okvt_pkg::VALUE_BITS'($urandom()),
                      (n == 0) && (round_no % 2 == 0));
            counted++;
         end
         round_no++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (stim_q.size() != 0 || req_valid || beats_due != beats_done);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (awaited_beats.size() != 0)
         report_mismatch($sformatf("%0d response beats never arrived", awaited_beats.size()));

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
